FILE: hw/rtl/permutation_rotation_rank_decoder_core_assert.svh
// Assertion macros for the permutation rotation rank decoder.
// Each macro checks a property on the rising edge of the given clock.
// The check is switched off while the given reset is high.
`ifndef PERMUTATION_ROTATION_RANK_DECODER_CORE_ASSERT_SVH
`define PERMUTATION_ROTATION_RANK_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PRRD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prrd assertion failed");
`define PRRD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prrd assertion failed");
`else
`define PRRD_ASSERT_IMP(label, clk, rst, ante, cons)
`define PRRD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/prrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation rotation rank decoder package
// Shared widths, the queue entry type and the rank weight table.
// ----------------------------------------------------------------------------
package prrd_pkg;

  localparam int MaxLength = 8;
  localparam int PosW      = 3;
  localparam int RotW      = 2;
  localparam int LenW      = 4;
  localparam int RankW     = 28;
  localparam int IdxW      = $clog2(MaxLength);
  localparam int DigitW    = 5;
  localparam int WeightW   = 24;
  localparam int ProdW     = DigitW + WeightW;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = QPtrW + 1;

  localparam logic [LenW-1:0] LenReset = 4'd4;
  localparam logic [LenW-1:0] LenMin   = 4'd1;
  localparam logic [LenW-1:0] LenMax   = 4'd8;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [IdxW-1:0]   k;
    logic              last;
    logic              err;
  } elem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // k! * 3^k
  function automatic logic [WeightW-1:0] weight(input logic [IdxW-1:0] k);
    logic [WeightW-1:0] w;
    case (k)
      3'd0:    w = 24'd1;
      3'd1:    w = 24'd3;
      3'd2:    w = 24'd18;
      3'd3:    w = 24'd162;
      3'd4:    w = 24'd1944;
      3'd5:    w = 24'd29160;
      3'd6:    w = 24'd524880;
      3'd7:    w = 24'd11022480;
      default: w = 24'd1;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/permutation_rotation_rank_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation rotation rank decoder
// Decodes groups of position and rotation elements into a mixed-radix rank.
// ----------------------------------------------------------------------------
// Elements arrive on the in channel (position, rotation) and each group of
// perm_length elements yields one request on the out channel (rank,
// bad_group). The cfg channel writes perm_length and drops any partly
// received group; it is always ready. It is to be used only while the block
// is idle; the block itself does not enforce this. The block takes one
// element per cycle while the queue has room. An element is classified by
// the front end in the cycle it is accepted, and the back end takes it from
// a four-entry queue after it is written there; one 5 by 24 bit multiply
// and a 28-bit add finish it. out_valid rises at the clock edge that pops
// the last element of its group from the queue. Reset sets perm_length to
// four and clears the open group, the queue and out_valid. While the
// receiver stalls, elements that do not close a group keep draining; the
// queue fills behind a closing element, and in_ready falls once it is full.
// ----------------------------------------------------------------------------
`include "permutation_rotation_rank_decoder_core_assert.svh"

module permutation_rotation_rank_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [prrd_pkg::LenW-1:0]  perm_length,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prrd_pkg::PosW-1:0]  position,
  input  logic [prrd_pkg::RotW-1:0]  rotation,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [prrd_pkg::RankW-1:0] rank,
  output logic                       bad_group
);

  logic                cfg_fire;
  logic                push;
  logic                pop;
  prrd_pkg::elem_t     push_elem;
  prrd_pkg::elem_t     head;
  prrd_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  prrd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_fire    (cfg_fire),
    .perm_length (perm_length),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .position    (position),
    .rotation    (rotation),
    .q_status    (q_status),
    .push        (push),
    .elem        (push_elem)
  );

  prrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_elem (push_elem),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  prrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_fire),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rank      (rank),
    .bad_group (bad_group)
  );

  `PRRD_ASSERT_IMP(a_no_push_when_full, clk, rst, in_valid && in_ready, !q_status.full)
  `PRRD_ASSERT_IMP(a_close_needs_slot, clk, rst, pop && head.last, !out_valid || out_ready)
  `PRRD_ASSERT_IMP(a_result_from_close, clk, rst, $rose(out_valid), $past(pop && head.last))
  `PRRD_ASSERT_NXT(a_pop_not_empty, clk, rst, q_status.empty && !push, !pop)

endmodule

FILE: hw/rtl/prrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank decoder front end
// Accepts elements, tracks the used positions of the open group and turns
// each element into a digit, a weight index and group flags.
// ----------------------------------------------------------------------------
module prrd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_fire,
  input  logic [prrd_pkg::LenW-1:0] perm_length,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [prrd_pkg::PosW-1:0] position,
  input  logic [prrd_pkg::RotW-1:0] rotation,
  input  prrd_pkg::q_status_t       q_status,
  output logic                      push,
  output prrd_pkg::elem_t           elem
);

  logic [prrd_pkg::LenW-1:0]      length;
  logic [prrd_pkg::MaxLength-1:0] used_mask;
  logic [prrd_pkg::IdxW-1:0]      element_count;
  logic                           error_seen;

  logic [prrd_pkg::LenW-1:0]      p_eff;
  logic [prrd_pkg::LenW-1:0]      limit;
  logic [prrd_pkg::LenW-1:0]      s;
  logic [prrd_pkg::LenW-1:0]      count_next;
  logic                           bad_pos;
  logic                           last;

  always_comb begin
    if (length < prrd_pkg::LenMin) begin
      p_eff = prrd_pkg::LenMin;
    end else if (length > prrd_pkg::LenMax) begin
      p_eff = prrd_pkg::LenMax;
    end else begin
      p_eff = length;
    end
    limit = ({1'b0, position} < p_eff) ? {1'b0, position} : p_eff;
    s = '0;
    for (int j = 0; j < prrd_pkg::MaxLength; j++) begin
      if ((prrd_pkg::LenW'(j) < limit) && !used_mask[prrd_pkg::IdxW'(j)]) begin
        s = s + 1'b1;
      end
    end
    bad_pos    = ({1'b0, position} >= p_eff) || used_mask[position];
    count_next = {1'b0, element_count} + 1'b1;
    last       = count_next >= p_eff;
    elem.digit = prrd_pkg::DigitW'(s) * prrd_pkg::DigitW'(3)
               + prrd_pkg::DigitW'(rotation);
    elem.k     = prrd_pkg::IdxW'(p_eff - 1'b1 - {1'b0, element_count});
    elem.last  = last;
    elem.err   = error_seen | bad_pos;
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      length        <= prrd_pkg::LenReset;
      used_mask     <= '0;
      element_count <= '0;
      error_seen    <= 1'b0;
    end else if (cfg_fire) begin
      length        <= perm_length;
      used_mask     <= '0;
      element_count <= '0;
      error_seen    <= 1'b0;
    end else if (push) begin
      if (last) begin
        used_mask     <= '0;
        element_count <= '0;
        error_seen    <= 1'b0;
      end else begin
        if (!bad_pos) begin
          used_mask[position] <= 1'b1;
        end
        element_count <= prrd_pkg::IdxW'(count_next);
        error_seen    <= error_seen | bad_pos;
      end
    end
  end

endmodule

FILE: hw/rtl/prrd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank decoder element queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module prrd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  prrd_pkg::elem_t     push_elem,
  input  logic                pop,
  output prrd_pkg::elem_t     head,
  output prrd_pkg::q_status_t status
);

  prrd_pkg::elem_t            entries [prrd_pkg::QDepth];
  logic [prrd_pkg::QPtrW-1:0] wr_ptr;
  logic [prrd_pkg::QPtrW-1:0] rd_ptr;
  logic [prrd_pkg::QCntW-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = count == prrd_pkg::QCntW'(prrd_pkg::QDepth);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/prrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank decoder back end
// Multiplies each digit by its weight, accumulates the group rank and holds
// the finished result in the output register.
// ----------------------------------------------------------------------------
module prrd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_fire,
  input  prrd_pkg::q_status_t        q_status,
  input  prrd_pkg::elem_t            head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [prrd_pkg::RankW-1:0] rank,
  output logic                       bad_group
);

  logic [prrd_pkg::RankW-1:0] accumulator;
  logic [prrd_pkg::ProdW-1:0] product;
  logic [prrd_pkg::RankW-1:0] sum;

  assign product = prrd_pkg::ProdW'(head.digit) * prrd_pkg::ProdW'(prrd_pkg::weight(head.k));
  assign sum     = accumulator + product[prrd_pkg::RankW-1:0];
  assign pop     = !q_status.empty && (!head.last || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        accumulator <= '0;
      end else if (pop) begin
        if (head.last) begin
          accumulator <= '0;
          out_valid   <= 1'b1;
        end else begin
          accumulator <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      rank      <= sum;
      bad_group <= head.err;
    end
  end

endmodule

FILE: verif/permutation_rotation_rank_decoder_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank decoder checker
// Watches the cfg, in and out channels of the rank decoder. It keeps its own
// copy of the group length and the open group, predicts the rank and the
// error flag of every completed group, and compares each out request with
// the oldest prediction.
// ----------------------------------------------------------------------------
module permutation_rotation_rank_decoder_core_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [prrd_pkg::LenW-1:0]  perm_length,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [prrd_pkg::PosW-1:0]  position,
  input  logic [prrd_pkg::RotW-1:0]  rotation,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [prrd_pkg::RankW-1:0] rank,
  input  logic                       bad_group,
  output int                         error_count,
  output int                         groups_pending
);

  typedef struct packed {
    logic [prrd_pkg::RankW-1:0] rank;
    logic                       bad;
  } group_rank_t;

  group_rank_t expected_ranks[$];

  logic [prrd_pkg::LenW-1:0]      length_reg;
  logic [prrd_pkg::MaxLength-1:0] used_mask;
  int unsigned                    element_idx;
  logic [prrd_pkg::RankW-1:0]     partial_rank;
  logic                           bad_seen;

  // The weight of digit k is k! * 3^k, the product of 3*j for j = 1 to k.
  function automatic int unsigned digit_weight(input int unsigned k);
    int unsigned w;
    int unsigned j;
    w = 1;
    for (j = 1; j <= k; j++) w = w * 3 * j;
    return w;
  endfunction

  function automatic int unsigned group_length(input logic [prrd_pkg::LenW-1:0] len);
    if (32'(len) == 0) return 1;
    if (32'(len) > prrd_pkg::MaxLength) return prrd_pkg::MaxLength;
    return 32'(len);
  endfunction

  task automatic clear_group();
    used_mask    = '0;
    element_idx  = 0;
    partial_rank = '0;
    bad_seen     = 1'b0;
  endtask

  task automatic decode_element(input logic [prrd_pkg::PosW-1:0] pos,
                                input logic [prrd_pkg::RotW-1:0] rot);
    int unsigned p;
    int unsigned lim;
    int unsigned s;
    int unsigned j;
    logic [31:0] sum;
    group_rank_t done;
    p   = group_length(length_reg);
    lim = (32'(pos) < p) ? 32'(pos) : p;
    s   = 0;
    for (j = 0; j < lim; j++) begin
      if (!used_mask[prrd_pkg::IdxW'(j)]) s++;
    end
    if (32'(pos) >= p || used_mask[pos]) begin
      bad_seen = 1'b1;
    end else begin
      used_mask[pos] = 1'b1;
    end
    sum = 32'(partial_rank)
        + (3 * s + 32'(rot)) * digit_weight(p - 1 - element_idx);
    partial_rank = sum[prrd_pkg::RankW-1:0];
    element_idx++;
    if (element_idx >= p) begin
      done.rank = partial_rank;
      done.bad  = bad_seen;
      expected_ranks.insert(expected_ranks.size(), done);
      clear_group();
    end
  endtask

  always @(posedge clk) begin : watch_channels
    group_rank_t want;
    if (rst) begin
      length_reg = prrd_pkg::LenReset;
      clear_group();
      expected_ranks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        length_reg = perm_length;
        clear_group();
      end
      if (out_valid && out_ready) begin
        if (expected_ranks.size() == 0) begin
          error_count++;
          $display("%0t: unexpected request: rank %0d bad_group %0b",
                   $time, rank, bad_group);
        end else begin
          want = expected_ranks.pop_front();
          if (rank !== want.rank) begin
            error_count++;
            $display("%0t: rank expected %0d actual %0d", $time, want.rank, rank);
          end
          if (bad_group !== want.bad) begin
            error_count++;
            $display("%0t: bad_group expected %0b actual %0b",
                     $time, want.bad, bad_group);
          end
        end
      end
      if (in_valid && in_ready) decode_element(position, rotation);
    end
    groups_pending = expected_ranks.size();
  end

endmodule

FILE: verif/permutation_rotation_rank_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank decoder testbench
// Drives groups of position and rotation elements into the rank decoder under
// several group lengths and several patterns of sender idling and receiver
// stalls. A checker beside the block predicts and compares every request.
// ----------------------------------------------------------------------------
module permutation_rotation_rank_decoder_core_tb;

  localparam int DrainCycles  = 8;
  localparam int QuietLimit   = 2000;
  localparam int SegmentItems = 100;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [prrd_pkg::LenW-1:0]  perm_length;
  logic                       in_valid;
  logic                       in_ready;
  logic [prrd_pkg::PosW-1:0]  position;
  logic [prrd_pkg::RotW-1:0]  rotation;
  logic                       out_valid;
  logic                       out_ready;
  logic [prrd_pkg::RankW-1:0] rank;
  logic                       bad_group;

  int error_count;
  int groups_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  logic [prrd_pkg::LenW-1:0] seg_lengths[16] =
    '{8, 1, 4, 15, 0, 2, 3, 5, 6, 7, 12, 9, 1, 8, 4, 3};

  permutation_rotation_rank_decoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .perm_length (perm_length),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .position    (position),
    .rotation    (rotation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rank        (rank),
    .bad_group   (bad_group)
  );

  permutation_rotation_rank_decoder_core_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .perm_length    (perm_length),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .position       (position),
    .rotation       (rotation),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rank           (rank),
    .bad_group      (bad_group),
    .error_count    (error_count),
    .groups_pending (groups_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_element(input logic [prrd_pkg::PosW-1:0] pos,
                              input logic [prrd_pkg::RotW-1:0] rot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= pos;
    rotation <= rot;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_length(input logic [prrd_pkg::LenW-1:0] len);
    cfg_valid   <= 1'b1;
    perm_length <= len;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Elements of an open group may still sit in the block after the last rank
  // has arrived, so a length write also waits out the drain argument.
  task automatic wait_for_ranks(input int drain);
    in_valid <= 1'b0;
    while (groups_pending != 0) @(negedge clk);
    repeat (drain) @(negedge clk);
  endtask

  task automatic run_segment(input logic [prrd_pkg::LenW-1:0] len);
    int unsigned p;
    int unsigned sent;
    int unsigned n;
    int unsigned i;
    int unsigned pick;
    int unsigned tmp;
    int unsigned order[prrd_pkg::MaxLength];
    bit          paused;
    wait_for_ranks(DrainCycles);
    write_length(len);
    p      = (32'(len) == 0) ? 1 :
             ((32'(len) > prrd_pkg::MaxLength) ? prrd_pkg::MaxLength : 32'(len));
    sent   = 0;
    paused = 1'b0;
    while (sent < SegmentItems) begin
      if ($urandom_range(9) < 8) begin
        for (i = 0; i < p; i++) order[i] = i;
        for (i = p; i > 1; i--) begin
          pick         = $urandom_range(i - 1);
          tmp          = order[i-1];
          order[i-1]   = order[pick];
          order[pick]  = tmp;
        end
        for (i = 0; i < p; i++) begin
          send_element(prrd_pkg::PosW'(order[i]),
                       prrd_pkg::RotW'(($urandom_range(19) == 0) ? 3 : $urandom_range(2)));
          sent++;
        end
      end else begin
        n = $urandom_range(prrd_pkg::MaxLength, 1);
        repeat (n) begin
          send_element(prrd_pkg::PosW'($urandom_range(7)),
                       prrd_pkg::RotW'($urandom_range(3)));
          sent++;
        end
      end
      if (!paused && sent >= SegmentItems / 2) begin
        wait_for_ranks(0);
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    int unsigned i;
    int          ph;
    int          seg;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    perm_length = prrd_pkg::LenReset;
    in_valid    = 1'b0;
    position    = '0;
    rotation    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Length four from reset: identity, reversed, then a group with a repeated
    // position, a position out of range and rotation three.
    for (i = 0; i < 4; i++) send_element(prrd_pkg::PosW'(i), 0);
    for (i = 0; i < 4; i++) send_element(prrd_pkg::PosW'(3 - i), 2);
    send_element(1, 3);
    send_element(1, 3);
    send_element(7, 3);
    send_element(0, 1);
    wait_for_ranks(DrainCycles);
    write_length(8);
    for (i = 0; i < 8; i++) send_element(prrd_pkg::PosW'(7 - i), 2);
    wait_for_ranks(DrainCycles);
    write_length(0);
    send_element(0, 3);
    send_element(7, 1);
    wait_for_ranks(DrainCycles);
    write_length(15);
    send_element(7, 0);
    send_element(6, 1);
    send_element(5, 2);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      for (seg = 0; seg < 4; seg++) run_segment(seg_lengths[ph*4+seg]);
    end

    wait_for_ranks(DrainCycles);
    if (error_count == 0 && groups_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
